// ===== hdl/i2cbm_pkg.sv =====
// Package for the byte-level I2C master: payload and config types, phase codes,
// command codes, register indexes and reset values.
// No dependencies.
package i2cbm_pkg;

   localparam int HalfPeriodWidth = 16;
   localparam int TimeoutWidth    = 8;
   localparam int CsrIndexWidth   = 2;
   localparam int CsrDataWidth    = 16;

   localparam logic [HalfPeriodWidth-1:0] HalfPeriodReset = 16'd250;
   localparam logic [TimeoutWidth-1:0]    TimeoutReset    = 8'd50;

   // register indexes
   localparam logic [CsrIndexWidth-1:0] CSR_HALF_PERIOD = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_ACK_TIMEOUT = 2'd1;

   // command codes
   localparam logic [2:0] CMD_NONE     = 3'd0;
   localparam logic [2:0] CMD_START    = 3'd1;
   localparam logic [2:0] CMD_STOP     = 3'd2;
   localparam logic [2:0] CMD_WRITE    = 3'd3;
   localparam logic [2:0] CMD_RD_ACK   = 3'd4;
   localparam logic [2:0] CMD_RD_NACK  = 3'd5;

   // controller phases
   localparam logic [3:0] PH_IDLE    = 4'd0;
   localparam logic [3:0] PH_ST_A    = 4'd1;
   localparam logic [3:0] PH_ST_B    = 4'd2;
   localparam logic [3:0] PH_SP_A    = 4'd3;
   localparam logic [3:0] PH_SP_B    = 4'd4;
   localparam logic [3:0] PH_WR_LOW  = 4'd5;
   localparam logic [3:0] PH_WR_HIGH = 4'd6;
   localparam logic [3:0] PH_AK_REL  = 4'd7;
   localparam logic [3:0] PH_AK_HIGH = 4'd8;
   localparam logic [3:0] PH_AK_POLL = 4'd9;
   localparam logic [3:0] PH_TO_A    = 4'd10;
   localparam logic [3:0] PH_TO_B    = 4'd11;
   localparam logic [3:0] PH_RD_LOW  = 4'd12;
   localparam logic [3:0] PH_RD_HIGH = 4'd13;
   localparam logic [3:0] PH_RA_LOW  = 4'd14;
   localparam logic [3:0] PH_RA_HIGH = 4'd15;

   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] data_in;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic       done_res;
      logic       ack_error;
      logic [7:0] read_data;
   } rsp_type;

   typedef struct packed {
      logic [HalfPeriodWidth-1:0] half_period_ticks;
      logic [TimeoutWidth-1:0]    ack_timeout;
   } cfg_type;

endpackage

// ===== hdl/i2c_byte_master_unit.sv =====
// A word's result reaches rsp_data through the input register, then the result
// register. Throughput: one word per cycle, each word being one bus tick, while
// rsp_stall does not hold the result register; the result register frees as it is taken.
// Synchronous active-high reset: controller idle, SCL and SDA released,
// counters and read byte zero, half period 250 ticks, ack timeout 50.
// Top level of the I2C byte master; depends on i2cbm_pkg and i2cbm_core.
module i2c_byte_master_unit #(
   parameter logic [i2cbm_pkg::HalfPeriodWidth-1:0] HALF_PERIOD_RESET =
      i2cbm_pkg::HalfPeriodReset,
   parameter logic [i2cbm_pkg::TimeoutWidth-1:0] ACK_TIMEOUT_RESET =
      i2cbm_pkg::TimeoutReset
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  i2cbm_pkg::req_type                    req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output i2cbm_pkg::rsp_type                    rsp_data,
   input  logic                                  csr_we,
   input  logic [i2cbm_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [i2cbm_pkg::CsrDataWidth-1:0]    csr_wdata
);

   i2cbm_pkg::req_type req_ff;
   logic               req_valid_ff;
   i2cbm_pkg::rsp_type rsp_ff;
   logic               rsp_valid_ff;
   i2cbm_pkg::cfg_type cfg_ff;
   i2cbm_pkg::rsp_type rsp_next;
   logic               out_free;
   logic               step_en;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step_en   = req_valid_ff && out_free;
   assign req_stall = req_valid_ff && !out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_period_ticks <= HALF_PERIOD_RESET;
         cfg_ff.ack_timeout       <= ACK_TIMEOUT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            i2cbm_pkg::CSR_HALF_PERIOD:
               cfg_ff.half_period_ticks <= csr_wdata[i2cbm_pkg::HalfPeriodWidth-1:0];
            i2cbm_pkg::CSR_ACK_TIMEOUT:
               cfg_ff.ack_timeout <= csr_wdata[i2cbm_pkg::TimeoutWidth-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         req_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         rsp_ff <= rsp_next;
      end
   end

   i2cbm_core u_core (
      .clock    (clock),
      .reset    (reset),
      .step_en  (step_en),
      .req      (req_ff),
      .cfg      (cfg_ff),
      .rsp_next (rsp_next)
   );

endmodule

// ===== hdl/i2cbm_core.sv =====
// Bus controller of the I2C byte master: phase register, bit/tick counters and
// line levels, advanced by one tick per word. Depends on i2cbm_pkg.
module i2cbm_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               step_en,
   input  i2cbm_pkg::req_type req,
   input  i2cbm_pkg::cfg_type cfg,
   output i2cbm_pkg::rsp_type rsp_next
);

   logic [3:0]  phase_ff, phase_in;
   logic [3:0]  bit_index_ff, bit_index_in;
   logic [7:0]  shift_ff, shift_in;
   logic [15:0] tick_ff, tick_in;
   logic [7:0]  ack_wait_ff, ack_wait_in;
   logic        scl_ff, scl_in;
   logic        sda_ff, sda_in;
   logic        send_ack_ff, send_ack_in;
   logic [7:0]  last_read_ff, last_read_in;

   logic [15:0] tick_inc;
   logic [15:0] tick_adv;
   logic        elapsed;
   logic [3:0]  bit_inc;
   logic [7:0]  shift_up;
   logic        done, err;

   assign tick_inc = tick_ff + 16'd1;
   // zero half period behaves as one; a wrapped count also ends the period
   assign elapsed  = (tick_inc >= cfg.half_period_ticks) || (tick_inc == 16'd0);
   assign tick_adv = elapsed ? 16'd0 : tick_inc;
   assign bit_inc  = bit_index_ff + 4'd1;
   assign shift_up = {shift_ff[6:0], 1'b0};

   always_comb begin
      phase_in     = phase_ff;
      bit_index_in = bit_index_ff;
      shift_in     = shift_ff;
      tick_in      = tick_ff;
      ack_wait_in  = ack_wait_ff;
      scl_in       = scl_ff;
      sda_in       = sda_ff;
      send_ack_in  = send_ack_ff;
      last_read_in = last_read_ff;
      done         = 1'b0;
      err          = 1'b0;

      case (phase_ff)
         i2cbm_pkg::PH_IDLE: begin
            case (req.cmd)
               i2cbm_pkg::CMD_START: begin
                  scl_in   = 1'b1;
                  sda_in   = 1'b1;
                  phase_in = i2cbm_pkg::PH_ST_A;
                  tick_in  = '0;
               end
               i2cbm_pkg::CMD_STOP: begin
                  scl_in   = 1'b0;
                  sda_in   = 1'b0;
                  phase_in = i2cbm_pkg::PH_SP_A;
                  tick_in  = '0;
               end
               i2cbm_pkg::CMD_WRITE: begin
                  shift_in     = req.data_in;
                  bit_index_in = '0;
                  ack_wait_in  = '0;
                  scl_in       = 1'b0;
                  sda_in       = req.data_in[7];
                  phase_in     = i2cbm_pkg::PH_WR_LOW;
                  tick_in      = '0;
               end
               i2cbm_pkg::CMD_RD_ACK, i2cbm_pkg::CMD_RD_NACK: begin
                  send_ack_in  = (req.cmd == i2cbm_pkg::CMD_RD_ACK);
                  shift_in     = '0;
                  bit_index_in = '0;
                  scl_in       = 1'b0;
                  sda_in       = 1'b1;
                  phase_in     = i2cbm_pkg::PH_RD_LOW;
                  tick_in      = '0;
               end
               default: begin
               end
            endcase
         end
         i2cbm_pkg::PH_ST_A: begin
            tick_in = tick_adv;
            if (elapsed) begin
               sda_in   = 1'b0;
               phase_in = i2cbm_pkg::PH_ST_B;
            end
         end
         i2cbm_pkg::PH_ST_B: begin
            tick_in = tick_adv;
            if (elapsed) begin
               scl_in   = 1'b0;
               phase_in = i2cbm_pkg::PH_IDLE;
               done     = 1'b1;
            end
         end
         i2cbm_pkg::PH_SP_A, i2cbm_pkg::PH_TO_A: begin
            tick_in = tick_adv;
            if (elapsed) begin
               scl_in   = 1'b1;
               sda_in   = 1'b1;
               phase_in = (phase_ff == i2cbm_pkg::PH_SP_A) ? i2cbm_pkg::PH_SP_B
                                                           : i2cbm_pkg::PH_TO_B;
            end
         end
         i2cbm_pkg::PH_SP_B, i2cbm_pkg::PH_TO_B: begin
            tick_in = tick_adv;
            if (elapsed) begin
               err      = (phase_ff == i2cbm_pkg::PH_TO_B);
               phase_in = i2cbm_pkg::PH_IDLE;
               done     = 1'b1;
            end
         end
         i2cbm_pkg::PH_WR_LOW: begin
            tick_in = tick_adv;
            if (elapsed) begin
               scl_in   = 1'b1;
               phase_in = i2cbm_pkg::PH_WR_HIGH;
            end
         end
         i2cbm_pkg::PH_WR_HIGH: begin
            tick_in = tick_adv;
            if (elapsed) begin
               scl_in       = 1'b0;
               shift_in     = shift_up;
               bit_index_in = bit_inc;
               if (bit_inc < 4'd8) begin
                  sda_in   = shift_up[7];
                  phase_in = i2cbm_pkg::PH_WR_LOW;
               end else begin
                  sda_in   = 1'b1;
                  phase_in = i2cbm_pkg::PH_AK_REL;
               end
            end
         end
         i2cbm_pkg::PH_AK_REL: begin
            tick_in = tick_adv;
            if (elapsed) begin
               scl_in   = 1'b1;
               phase_in = i2cbm_pkg::PH_AK_HIGH;
            end
         end
         i2cbm_pkg::PH_AK_HIGH: begin
            tick_in = tick_adv;
            if (elapsed) begin
               phase_in = i2cbm_pkg::PH_AK_POLL;
            end
         end
         i2cbm_pkg::PH_AK_POLL: begin
            // sample SDA at the start of each half period
            if (tick_ff == 16'd0) begin
               if (!req.sda_in) begin
                  scl_in   = 1'b0;
                  phase_in = i2cbm_pkg::PH_IDLE;
                  done     = 1'b1;
               end else if (ack_wait_ff >= cfg.ack_timeout) begin
                  scl_in   = 1'b0;
                  sda_in   = 1'b0;
                  phase_in = i2cbm_pkg::PH_TO_A;
               end else begin
                  ack_wait_in = ack_wait_ff + 8'd1;
                  tick_in     = (cfg.half_period_ticks <= 16'd1) ? 16'd0 : 16'd1;
               end
            end else begin
               tick_in = tick_adv;
            end
         end
         i2cbm_pkg::PH_RD_LOW: begin
            tick_in = tick_adv;
            if (elapsed) begin
               scl_in   = 1'b1;
               shift_in = {shift_ff[6:0], req.sda_in};
               phase_in = i2cbm_pkg::PH_RD_HIGH;
            end
         end
         i2cbm_pkg::PH_RD_HIGH: begin
            tick_in = tick_adv;
            if (elapsed) begin
               scl_in       = 1'b0;
               bit_index_in = bit_inc;
               if (bit_inc < 4'd8) begin
                  phase_in = i2cbm_pkg::PH_RD_LOW;
               end else begin
                  sda_in   = !send_ack_ff;
                  phase_in = i2cbm_pkg::PH_RA_LOW;
               end
            end
         end
         i2cbm_pkg::PH_RA_LOW: begin
            tick_in = tick_adv;
            if (elapsed) begin
               scl_in   = 1'b1;
               phase_in = i2cbm_pkg::PH_RA_HIGH;
            end
         end
         i2cbm_pkg::PH_RA_HIGH: begin
            tick_in = tick_adv;
            if (elapsed) begin
               scl_in       = 1'b0;
               last_read_in = shift_ff;
               phase_in     = i2cbm_pkg::PH_IDLE;
               done         = 1'b1;
            end
         end
         default: begin
            phase_in = i2cbm_pkg::PH_IDLE;
            tick_in  = '0;
         end
      endcase
   end

   always_comb begin
      rsp_next.scl_out   = scl_in;
      rsp_next.sda_out   = sda_in;
      rsp_next.busy_res  = (phase_in != i2cbm_pkg::PH_IDLE);
      rsp_next.done_res  = done;
      rsp_next.ack_error = err;
      rsp_next.read_data = last_read_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= i2cbm_pkg::PH_IDLE;
         bit_index_ff <= '0;
         shift_ff     <= '0;
         tick_ff      <= '0;
         ack_wait_ff  <= '0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         send_ack_ff  <= 1'b0;
         last_read_ff <= '0;
      end else if (step_en) begin
         phase_ff     <= phase_in;
         bit_index_ff <= bit_index_in;
         shift_ff     <= shift_in;
         tick_ff      <= tick_in;
         ack_wait_ff  <= ack_wait_in;
         scl_ff       <= scl_in;
         sda_ff       <= sda_in;
         send_ack_ff  <= send_ack_in;
         last_read_ff <= last_read_in;
      end
   end

   a_error_with_done: assert property (@(posedge clock) disable iff (reset)
      rsp_next.ack_error |-> rsp_next.done_res)
      else $error("ack error without command completion");

   a_done_goes_idle: assert property (@(posedge clock) disable iff (reset)
      step_en && rsp_next.done_res |=> phase_ff == i2cbm_pkg::PH_IDLE)
      else $error("controller not idle after completion");

   a_idle_tick_clear: assert property (@(posedge clock) disable iff (reset)
      phase_ff == i2cbm_pkg::PH_IDLE |-> tick_ff == 16'd0)
      else $error("tick counter running while idle");

   a_bit_range: assert property (@(posedge clock) disable iff (reset)
      bit_index_ff <= 4'd8)
      else $error("bit index beyond byte");

   a_scl_high_phase: assert property (@(posedge clock) disable iff (reset)
      phase_ff == i2cbm_pkg::PH_WR_HIGH || phase_ff == i2cbm_pkg::PH_RD_HIGH ||
      phase_ff == i2cbm_pkg::PH_AK_POLL || phase_ff == i2cbm_pkg::PH_RA_HIGH
      |-> scl_ff)
      else $error("SCL low during a high half period");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking bench for i2c_byte_master_unit: a tick-accurate model of the byte
// master predicts every result word, which is compared in order with the DUT's.
// Depends on i2cbm_pkg and the RTL top i2c_byte_master_unit.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // codes the block must ignore
   localparam logic [2:0] CMD_BAD_LO = 3'd6;
   localparam logic [2:0] CMD_BAD_HI = 3'd7;
   localparam logic [i2cbm_pkg::CsrIndexWidth-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [i2cbm_pkg::CsrIndexWidth-1:0] CSR_SPARE_3 = 2'd3;
   localparam int PIPE_SETTLE = 4;
   localparam int RANDOM_TICKS = 300;

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall;
   i2cbm_pkg::req_type req_data;
   i2cbm_pkg::rsp_type rsp_data;
   logic csr_we;
   logic [i2cbm_pkg::CsrIndexWidth-1:0] csr_index;
   logic [i2cbm_pkg::CsrDataWidth-1:0] csr_wdata;

   i2c_byte_master_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   // bus controller model
   logic [15:0] half_ticks;
   logic [7:0] tmo_limit;
   logic [3:0] phase;
   logic [3:0] bit_cnt;
   logic [7:0] shift_q;
   logic [15:0] tick_cnt;
   logic [7:0] ack_polls;
   logic scl_lvl, sda_lvl, ack_flag;
   logic [7:0] rd_byte;

   i2cbm_pkg::rsp_type bus_levels_q[$];
   int fail_cnt, checked_cnt, words_sent, csr_writes, ack_timeouts;
   int cmd_seen[8];
   bit send_idle, stall_on;
   int hold_cnt;

   function automatic void model_reset();
      half_ticks = i2cbm_pkg::HalfPeriodReset;
      tmo_limit = i2cbm_pkg::TimeoutReset;
      phase = i2cbm_pkg::PH_IDLE;
      bit_cnt = '0;
      shift_q = '0;
      tick_cnt = '0;
      ack_polls = '0;
      scl_lvl = 1'b1;
      sda_lvl = 1'b1;
      ack_flag = 1'b0;
      rd_byte = '0;
   endfunction

   function automatic void enter_phase(logic [3:0] p);
      phase = p;
      tick_cnt = '0;
   endfunction

   // a half period of 0 acts as 1
   function automatic logic half_done();
      tick_cnt = tick_cnt + 16'd1;
      if (tick_cnt >= half_ticks || tick_cnt == 16'd0) begin
         tick_cnt = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic i2cbm_pkg::rsp_type master_tick(i2cbm_pkg::req_type w);
      i2cbm_pkg::rsp_type r;
      logic done, err;
      done = 1'b0;
      err = 1'b0;
      case (phase)
         i2cbm_pkg::PH_IDLE: begin
            case (w.cmd)
               i2cbm_pkg::CMD_START: begin
                  sda_lvl = 1'b1;
                  scl_lvl = 1'b1;
                  enter_phase(i2cbm_pkg::PH_ST_A);
               end
               i2cbm_pkg::CMD_STOP: begin
                  scl_lvl = 1'b0;
                  sda_lvl = 1'b0;
                  enter_phase(i2cbm_pkg::PH_SP_A);
               end
               i2cbm_pkg::CMD_WRITE: begin
                  shift_q = w.data_in;
                  bit_cnt = '0;
                  ack_polls = '0;
                  scl_lvl = 1'b0;
                  sda_lvl = shift_q[7];
                  enter_phase(i2cbm_pkg::PH_WR_LOW);
               end
               i2cbm_pkg::CMD_RD_ACK, i2cbm_pkg::CMD_RD_NACK: begin
                  ack_flag = (w.cmd == i2cbm_pkg::CMD_RD_ACK);
                  shift_q = '0;
                  bit_cnt = '0;
                  scl_lvl = 1'b0;
                  sda_lvl = 1'b1;
                  enter_phase(i2cbm_pkg::PH_RD_LOW);
               end
               default: ;
            endcase
         end
         i2cbm_pkg::PH_ST_A: if (half_done()) begin
            sda_lvl = 1'b0;
            enter_phase(i2cbm_pkg::PH_ST_B);
         end
         i2cbm_pkg::PH_ST_B: if (half_done()) begin
            scl_lvl = 1'b0;
            enter_phase(i2cbm_pkg::PH_IDLE);
            done = 1'b1;
         end
         i2cbm_pkg::PH_SP_A, i2cbm_pkg::PH_TO_A: if (half_done()) begin
            scl_lvl = 1'b1;
            sda_lvl = 1'b1;
            enter_phase(phase == i2cbm_pkg::PH_SP_A ? i2cbm_pkg::PH_SP_B
                                                    : i2cbm_pkg::PH_TO_B);
         end
         i2cbm_pkg::PH_SP_B, i2cbm_pkg::PH_TO_B: if (half_done()) begin
            err = (phase == i2cbm_pkg::PH_TO_B);
            enter_phase(i2cbm_pkg::PH_IDLE);
            done = 1'b1;
         end
         i2cbm_pkg::PH_WR_LOW: if (half_done()) begin
            scl_lvl = 1'b1;
            enter_phase(i2cbm_pkg::PH_WR_HIGH);
         end
         i2cbm_pkg::PH_WR_HIGH: if (half_done()) begin
            scl_lvl = 1'b0;
            shift_q = shift_q << 1;
            bit_cnt = bit_cnt + 4'd1;
            if (bit_cnt < 4'd8) begin
               sda_lvl = shift_q[7];
               enter_phase(i2cbm_pkg::PH_WR_LOW);
            end else begin
               sda_lvl = 1'b1;
               enter_phase(i2cbm_pkg::PH_AK_REL);
            end
         end
         i2cbm_pkg::PH_AK_REL: if (half_done()) begin
            scl_lvl = 1'b1;
            enter_phase(i2cbm_pkg::PH_AK_HIGH);
         end
         i2cbm_pkg::PH_AK_HIGH: if (half_done()) enter_phase(i2cbm_pkg::PH_AK_POLL);
         i2cbm_pkg::PH_AK_POLL: begin
            // SDA is looked at only on the first tick of each half period
            if (tick_cnt == 16'd0) begin
               if (!w.sda_in) begin
                  scl_lvl = 1'b0;
                  enter_phase(i2cbm_pkg::PH_IDLE);
                  done = 1'b1;
               end else if (ack_polls >= tmo_limit) begin
                  scl_lvl = 1'b0;
                  sda_lvl = 1'b0;
                  enter_phase(i2cbm_pkg::PH_TO_A);
               end else begin
                  ack_polls = ack_polls + 8'd1;
                  tick_cnt = 16'd1;
                  if (tick_cnt >= half_ticks) tick_cnt = '0;
               end
            end else begin
               void'(half_done());
            end
         end
         i2cbm_pkg::PH_RD_LOW: if (half_done()) begin
            scl_lvl = 1'b1;
            shift_q = {shift_q[6:0], w.sda_in};
            enter_phase(i2cbm_pkg::PH_RD_HIGH);
         end
         i2cbm_pkg::PH_RD_HIGH: if (half_done()) begin
            scl_lvl = 1'b0;
            bit_cnt = bit_cnt + 4'd1;
            if (bit_cnt < 4'd8) begin
               enter_phase(i2cbm_pkg::PH_RD_LOW);
            end else begin
               sda_lvl = !ack_flag;
               enter_phase(i2cbm_pkg::PH_RA_LOW);
            end
         end
         i2cbm_pkg::PH_RA_LOW: if (half_done()) begin
            scl_lvl = 1'b1;
            enter_phase(i2cbm_pkg::PH_RA_HIGH);
         end
         i2cbm_pkg::PH_RA_HIGH: if (half_done()) begin
            scl_lvl = 1'b0;
            rd_byte = shift_q;
            enter_phase(i2cbm_pkg::PH_IDLE);
            done = 1'b1;
         end
         default: enter_phase(i2cbm_pkg::PH_IDLE);
      endcase
      r.scl_out = scl_lvl;
      r.sda_out = sda_lvl;
      r.busy_res = (phase != i2cbm_pkg::PH_IDLE);
      r.done_res = done;
      r.ack_error = err;
      r.read_data = rd_byte;
      return r;
   endfunction

   // mostly no gap, some short ones, a few long
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic sda_pick(int low_pct);
      return ($urandom_range(0, 99) < low_pct) ? 1'b0 : 1'b1;
   endfunction

   always @(negedge clock) begin
      if (hold_cnt != 0) begin
         rsp_stall <= 1'b1;
         hold_cnt = hold_cnt - 1;
      end else begin
         rsp_stall <= 1'b0;
         if (stall_on) hold_cnt = idle_len();
      end
   end

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s mismatch: expected %0h actual %0h", name, want, got);
         fail_cnt++;
      end
   endtask

   always @(posedge clock) begin
      i2cbm_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (bus_levels_q.size() == 0) begin
            $error("result word %h arrived with none outstanding", rsp_data);
            fail_cnt++;
         end else begin
            want = bus_levels_q.pop_front();
            checked_cnt++;
            check_field("scl_out", want.scl_out, rsp_data.scl_out);
            check_field("sda_out", want.sda_out, rsp_data.sda_out);
            check_field("busy_res", want.busy_res, rsp_data.busy_res);
            check_field("done_res", want.done_res, rsp_data.done_res);
            check_field("ack_error", want.ack_error, rsp_data.ack_error);
            check_field("read_data", want.read_data, rsp_data.read_data);
         end
      end
   end

   // one bus tick; the model advances when the DUT takes the word
   task automatic send_word(logic [2:0] c, logic [7:0] d, logic s);
      i2cbm_pkg::req_type w;
      i2cbm_pkg::rsp_type r;
      int gap;
      w.cmd = c;
      w.data_in = d;
      w.sda_in = s;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (phase == i2cbm_pkg::PH_IDLE) cmd_seen[c]++;
      r = master_tick(w);
      if (r.ack_error) ack_timeouts++;
      bus_levels_q.push_back(r);
      words_sent++;
      gap = send_idle ? idle_len() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // issue a command and keep ticking until the controller is idle again;
   // noise_pct sets how often a command is thrown at it while busy
   task automatic run_cmd(logic [2:0] c, logic [7:0] d, int low_pct, int noise_pct);
      logic [2:0] c_busy;
      send_word(c, d, sda_pick(low_pct));
      while (phase != i2cbm_pkg::PH_IDLE) begin
         c_busy = ($urandom_range(0, 99) < noise_pct) ? 3'($urandom_range(1, 7))
                                                      : i2cbm_pkg::CMD_NONE;
         send_word(c_busy, 8'($urandom), sda_pick(low_pct));
      end
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (bus_levels_q.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [i2cbm_pkg::CsrIndexWidth-1:0] idx,
                            logic [i2cbm_pkg::CsrDataWidth-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         i2cbm_pkg::CSR_HALF_PERIOD: half_ticks = val;
         i2cbm_pkg::CSR_ACK_TIMEOUT: tmo_limit = val[7:0];
         default: ;
      endcase
      csr_writes++;
   endtask

   // upper byte of the timeout write is junk the block must drop
   task automatic set_bus(logic [15:0] h, logic [7:0] t);
      settle();
      csr_write(i2cbm_pkg::CSR_HALF_PERIOD, h);
      csr_write(i2cbm_pkg::CSR_ACK_TIMEOUT, {8'($urandom), t});
   endtask

   task automatic test_reset_values();
      send_word(i2cbm_pkg::CMD_NONE, 8'hFF, 1'b1);
      send_word(CMD_BAD_LO, 8'h00, 1'b0);
      send_word(CMD_BAD_HI, 8'hFF, 1'b1);
      run_cmd(i2cbm_pkg::CMD_START, 8'h00, 50, 0);
   endtask

   task automatic test_csr_regs();
      set_bus(16'd0, 8'd0);
      csr_write(CSR_SPARE_2, 16'hFFFF);
      csr_write(CSR_SPARE_3, 16'h0001);
      // zero timeout: first high poll ends in stop with error
      run_cmd(i2cbm_pkg::CMD_WRITE, 8'h5A, 0, 0);
   endtask

   task automatic test_directed_cmds();
      set_bus(16'd1, 8'd2);
      run_cmd(i2cbm_pkg::CMD_START, 8'h00, 50, 0);
      run_cmd(i2cbm_pkg::CMD_WRITE, 8'hFF, 100, 0);
      run_cmd(i2cbm_pkg::CMD_WRITE, 8'h00, 0, 0);
      run_cmd(i2cbm_pkg::CMD_RD_ACK, 8'h00, 0, 0);
      run_cmd(i2cbm_pkg::CMD_RD_NACK, 8'hFF, 100, 0);
      send_word(CMD_BAD_HI, 8'h81, 1'b0);
      run_cmd(i2cbm_pkg::CMD_RD_ACK, 8'h00, 50, 0);
      run_cmd(i2cbm_pkg::CMD_WRITE, 8'hA5, 40, 100);
      run_cmd(i2cbm_pkg::CMD_STOP, 8'h00, 50, 0);
   endtask

   task automatic test_config_extremes();
      set_bus(16'd1, 8'd255);
      run_cmd(i2cbm_pkg::CMD_WRITE, 8'h3C, 0, 0);
      // longer half period with words back to back on both sides
      send_idle = 0;
      stall_on = 0;
      set_bus(16'd40, 8'd1);
      run_cmd(i2cbm_pkg::CMD_START, 8'h00, 50, 0);
      send_idle = 1;
      stall_on = 1;
   endtask

   task automatic random_command();
      int r;
      logic [2:0] c;
      int low;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         c = (r < 4) ? i2cbm_pkg::CMD_NONE : ((r < 7) ? CMD_BAD_LO : CMD_BAD_HI);
         send_word(c, 8'($urandom), 1'($urandom));
         return;
      end
      if (r < 20) c = i2cbm_pkg::CMD_START;
      else if (r < 30) c = i2cbm_pkg::CMD_STOP;
      else if (r < 65) c = i2cbm_pkg::CMD_WRITE;
      else if (r < 83) c = i2cbm_pkg::CMD_RD_ACK;
      else c = i2cbm_pkg::CMD_RD_NACK;
      if (c == i2cbm_pkg::CMD_WRITE) begin
         low = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(20, 100);
      end else begin
         low = $urandom_range(0, 100);
      end
      run_cmd(c, 8'($urandom), low, ($urandom_range(0, 3) == 0) ? 30 : 0);
   endtask

   task automatic test_random_traffic();
      int first;
      first = words_sent;
      while (words_sent - first < RANDOM_TICKS) begin
         set_bus(16'($urandom_range(0, 3)), 8'($urandom_range(0, 6)));
         send_idle = ($urandom_range(0, 3) != 0);
         stall_on = ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(3, 6)) random_command();
      end
      send_idle = 1;
      stall_on = 1;
   endtask

   initial begin
      #4_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      hold_cnt = 0;
      send_idle = 1;
      stall_on = 1;
      model_reset();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_csr_regs();
      test_directed_cmds();
      test_config_extremes();
      test_random_traffic();

      settle();
      repeat (PIPE_SETTLE) @(posedge clock);
      $display("Ran %0d bus ticks (%0d checked) across %0d register writes.",
               words_sent, checked_cnt, csr_writes);
      $display("Commands: %0d start, %0d stop, %0d write, %0d read; %0d ack timeouts.",
               cmd_seen[i2cbm_pkg::CMD_START], cmd_seen[i2cbm_pkg::CMD_STOP],
               cmd_seen[i2cbm_pkg::CMD_WRITE],
               cmd_seen[i2cbm_pkg::CMD_RD_ACK] + cmd_seen[i2cbm_pkg::CMD_RD_NACK],
               ack_timeouts);
      if (fail_cnt == 0 && bus_levels_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/i2cbm_pkg.sv
hdl/i2cbm_core.sv
hdl/i2c_byte_master_unit.sv
verif/tb_top.sv
